// File: rtl/core/crc8_framed_packet_receiver_macros.svh
// Assertion macros for the CRC-8 framed packet receiver.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC8FPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRC8FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/crc8fpr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package crc8fpr_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic [7:0]  CRC_POLY   = 8'h8C;
  localparam logic [7:0]  BYTE_CR    = 8'h0D;
  localparam logic [7:0]  BYTE_LF    = 8'h0A;
  localparam logic [8:0]  POS_MAX    = 9'd511;
  localparam logic [15:0] SYNC_RESET = 16'h55AA;
  localparam logic [7:0]  BASE_RESET = 8'd15;
  localparam logic [8:0]  FIELD_SPAN = 9'd16;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_TRAILER = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SYNC = 2'd1,
    ST_CRC  = 2'd2
  } status_e;

  typedef enum logic {
    REG_SYNC = 1'b0,
    REG_BASE = 1'b1
  } reg_e;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [7:0]  field_base;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic [31:0] word_four;
    logic [7:0]  flag;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crc8fpr_cfg.sv
// APB-style register file holding the sync word and the field base.
// Depends on crc8fpr_pkg.
`default_nettype none

module crc8fpr_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [crc8fpr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  output crc8fpr_pkg::cfg_t                      cfg_o
);

  logic [15:0] sync_q;
  logic [7:0]  base_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= crc8fpr_pkg::SYNC_RESET;
      base_q <= crc8fpr_pkg::BASE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        crc8fpr_pkg::REG_SYNC: sync_q <= pwdata[15:0];
        crc8fpr_pkg::REG_BASE: base_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      crc8fpr_pkg::REG_SYNC: prdata = {16'd0, sync_q};
      crc8fpr_pkg::REG_BASE: prdata = {24'd0, base_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o.sync_word  = sync_q;
  assign cfg_o.field_base = base_q;

endmodule

`default_nettype wire

// File: rtl/core/crc8fpr_deframer.sv
// Frame state, CRC accumulation and field capture, one word per cycle while fire_i is high.
// Depends on crc8fpr_pkg; produces the result of the current word when it closes a frame.
`default_nettype none

module crc8fpr_deframer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire crc8fpr_pkg::cfg_t  cfg_i,
  input  wire logic               fire_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    emit_o,
  output crc8fpr_pkg::res_t       res_o
);

  crc8fpr_pkg::phase_e phase_q, phase_d;
  logic [8:0]          pos_q, pos_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          len_q, len_d;
  logic                sbad_q, sbad_d;
  logic [7:0]          crcrx_q, crcrx_d;
  logic                cr_q, cr_d;
  logic [3:0][7:0]     words_q [4];
  logic [3:0][7:0]     words_d [4];
  logic [7:0]          flag_q, flag_d;

  logic                hunt;
  logic                was_cr;
  logic [8:0]          pos_eff;
  logic [8:0]          off;
  logic [7:0]          crc_upd;
  logic                is_lf_end;
  crc8fpr_pkg::status_e status;

  always_comb begin
    hunt    = (phase_q == crc8fpr_pkg::PH_HUNT);
    pos_eff = hunt ? 9'd0 : pos_q;
    crc_d   = hunt ? 8'd0 : crc_q;
    len_d   = hunt ? 8'd0 : len_q;
    crcrx_d = hunt ? 8'd0 : crcrx_q;
    was_cr  = hunt ? 1'b0 : cr_q;
    sbad_d  = hunt ? (rx_byte_i != cfg_i.sync_word[15:8]) : sbad_q;
    flag_d  = hunt ? 8'd0 : flag_q;
    for (int i = 0; i < 4; i++) begin
      words_d[i] = hunt ? '0 : words_q[i];
    end

    off = pos_eff - {1'b0, cfg_i.field_base};
    if (pos_eff >= {1'b0, cfg_i.field_base}) begin
      if (off < crc8fpr_pkg::FIELD_SPAN) begin
        words_d[off[3:2]][off[1:0]] = rx_byte_i;
      end else if (off == crc8fpr_pkg::FIELD_SPAN) begin
        flag_d = rx_byte_i;
      end
    end

    crc_upd   = crc8fpr_pkg::crc8_byte(crc_d, rx_byte_i);
    is_lf_end = (rx_byte_i == crc8fpr_pkg::BYTE_LF) && was_cr;
    emit_o    = 1'b0;
    phase_d   = phase_q;

    case (phase_q)
      crc8fpr_pkg::PH_HUNT: begin
        crc_d   = crc_upd;
        phase_d = crc8fpr_pkg::PH_SYNC2;
      end
      crc8fpr_pkg::PH_SYNC2: begin
        crc_d = crc_upd;
        if (rx_byte_i != cfg_i.sync_word[7:0]) begin
          sbad_d = 1'b1;
        end
        if (sbad_d) begin
          phase_d = crc8fpr_pkg::PH_TRAILER;
          emit_o  = is_lf_end;
        end else begin
          phase_d = crc8fpr_pkg::PH_LEN;
        end
      end
      crc8fpr_pkg::PH_LEN: begin
        crc_d   = crc_upd;
        len_d   = rx_byte_i;
        phase_d = (rx_byte_i == 8'd0) ? crc8fpr_pkg::PH_CRC : crc8fpr_pkg::PH_PAYLOAD;
      end
      crc8fpr_pkg::PH_PAYLOAD: begin
        crc_d = crc_upd;
        if (pos_eff >= (9'd2 + {1'b0, len_d})) begin
          phase_d = crc8fpr_pkg::PH_CRC;
        end
      end
      crc8fpr_pkg::PH_CRC: begin
        crcrx_d = rx_byte_i;
        phase_d = crc8fpr_pkg::PH_TRAILER;
      end
      default: begin
        emit_o = is_lf_end;
      end
    endcase

    cr_d  = (rx_byte_i == crc8fpr_pkg::BYTE_CR);
    pos_d = (pos_eff < crc8fpr_pkg::POS_MAX) ? (pos_eff + 9'd1) : pos_eff;

    if (emit_o) begin
      phase_d = crc8fpr_pkg::PH_HUNT;
      cr_d    = 1'b0;
    end

    if (sbad_d) begin
      status = crc8fpr_pkg::ST_SYNC;
    end else if (crcrx_d != crc_d) begin
      status = crc8fpr_pkg::ST_CRC;
    end else begin
      status = crc8fpr_pkg::ST_OK;
    end

    res_o.status = status;
    if (status == crc8fpr_pkg::ST_OK) begin
      res_o.word_one   = words_d[0];
      res_o.word_two   = words_d[1];
      res_o.word_three = words_d[2];
      res_o.word_four  = words_d[3];
      res_o.flag       = flag_d;
    end else begin
      res_o.word_one   = 32'd0;
      res_o.word_two   = 32'd0;
      res_o.word_three = 32'd0;
      res_o.word_four  = 32'd0;
      res_o.flag       = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crc8fpr_pkg::PH_HUNT;
      pos_q   <= 9'd0;
      crc_q   <= 8'd0;
      len_q   <= 8'd0;
      sbad_q  <= 1'b0;
      crcrx_q <= 8'd0;
      cr_q    <= 1'b0;
      flag_q  <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        words_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      sbad_q  <= sbad_d;
      crcrx_q <= crcrx_d;
      cr_q    <= cr_d;
      flag_q  <= flag_d;
      for (int i = 0; i < 4; i++) begin
        words_q[i] <= words_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc8fpr_outbuf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on crc8fpr_pkg for the result type.
`default_nettype none

module crc8fpr_outbuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire crc8fpr_pkg::res_t  res_i,
  output logic                    space_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output crc8fpr_pkg::res_t       res_o
);

  logic              head_vld_q;
  logic              skid_vld_q;
  crc8fpr_pkg::res_t head_q;
  crc8fpr_pkg::res_t skid_q;
  logic              pop;

  assign pop         = head_vld_q && out_ready_i;
  assign space_o     = !skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign res_o       = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q && pop) begin
      skid_vld_q <= 1'b0;
    end else if (push_i) begin
      if (!head_vld_q || pop) begin
        head_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      head_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q && pop) begin
      head_q <= skid_q;
    end else if (push_i) begin
      if (!head_vld_q || pop) begin
        head_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc8_framed_packet_receiver.sv
// Top level of the CRC-8 framed packet receiver: registers, deframer, result buffer.
// Depends on crc8fpr_pkg, crc8fpr_cfg, crc8fpr_deframer, crc8fpr_outbuf and the macros header.
//
//   Channel   Handshake                 Payload
//   in        in_valid_i / in_ready_o   rx_byte_i
//   out       out_valid_o / out_ready_i frame_status_o, word_one_o..word_four_o, control_flag_o
//   cfg       psel, penable, pwrite     paddr, pwdata, prdata (pready always high)
//
// One word is taken every cycle while in_ready_o is high; frame state and CRC update finish in the accept cycle.
// A result enters the output register the cycle after the closing LF word is accepted if the register is
// free or being read. A skid register holds a second result, so input stalls only when both are occupied.
// Reset is asynchronous and active low; it returns to sync hunt with cleared capture.
`default_nettype none

`include "crc8_framed_packet_receiver_macros.svh"

module crc8_framed_packet_receiver (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [crc8fpr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          frame_status_o,
  output logic [31:0]                         word_one_o,
  output logic [31:0]                         word_two_o,
  output logic [31:0]                         word_three_o,
  output logic [31:0]                         word_four_o,
  output logic [7:0]                          control_flag_o
);

  crc8fpr_pkg::cfg_t cfg;
  crc8fpr_pkg::res_t res_new;
  crc8fpr_pkg::res_t res_out;
  logic              fire;
  logic              emit;
  logic              space;

  assign in_ready_o = space;
  assign fire       = in_valid_i && in_ready_o;

  crc8fpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crc8fpr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .rx_byte_i (rx_byte_i),
    .emit_o    (emit),
    .res_o     (res_new)
  );

  crc8fpr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && emit),
    .res_i       (res_new),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign frame_status_o = res_out.status;
  assign word_one_o     = res_out.word_one;
  assign word_two_o     = res_out.word_two;
  assign word_three_o   = res_out.word_three;
  assign word_four_o    = res_out.word_four;
  assign control_flag_o = res_out.flag;

  `CRC8FPR_ASSERT_IMPL(a_err_fields_zero, out_valid_o && (frame_status_o != crc8fpr_pkg::ST_OK), (word_one_o == 32'd0) && (word_four_o == 32'd0) && (control_flag_o == 8'd0), "Error result carries nonzero captured fields.")
  `CRC8FPR_ASSERT_IMPL(a_stall_only_full, !in_ready_o, out_valid_o, "Input stalled while the output register is empty.")
  `CRC8FPR_ASSERT_NEXT(a_emit_shows, fire && emit, out_valid_o, "Closed frame did not produce a visible result.")

endmodule

`default_nettype wire

// File: dv/tb_crc8_framed_packet_receiver.sv
// Self-checking testbench for the CRC-8 framed packet receiver: a directed table,
// then random frames under several register settings, checked against a local predictor.
// Depends on crc8fpr_pkg and the crc8_framed_packet_receiver RTL.
`timescale 1ns / 1ps

module tb_crc8_framed_packet_receiver;

  localparam int IDLE_PCT       = 36;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_WORDS    = 65;
  localparam int MIN_FRAMES     = 24;
  localparam int NUM_PHASES     = 7;
  localparam int LONG_JUNK      = 500;
  localparam int BURST_FRAMES   = 6;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_CRC_RIGHT,
    SRC_CRC_WRONG
  } byte_src_e;

  typedef struct {
    logic [7:0]           value;
    byte_src_e            src;
    bit                   typed;
    crc8fpr_pkg::status_e status;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [crc8fpr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  wire  [31:0]                    prdata;
  wire                            pready;
  logic                           in_valid = 1'b0;
  wire                            in_ready;
  logic [7:0]                     rx_byte = '0;
  wire                            out_valid;
  logic                           out_ready = 1'b0;
  wire  [1:0]                     frame_status;
  wire  [31:0]                    word_one;
  wire  [31:0]                    word_two;
  wire  [31:0]                    word_three;
  wire  [31:0]                    word_four;
  wire  [7:0]                     control_flag;

  // Predictor state and its copy of the registers.
  logic [15:0]         cfg_sync = crc8fpr_pkg::SYNC_RESET;
  logic [7:0]          cfg_base = crc8fpr_pkg::BASE_RESET;
  crc8fpr_pkg::phase_e fr_phase = crc8fpr_pkg::PH_HUNT;
  logic [8:0]          fr_pos = '0;
  logic [7:0]          fr_crc = '0;
  logic [7:0]          fr_len = '0;
  logic [7:0]          fr_crc_rx = '0;
  bit                  fr_sync_bad = 1'b0;
  bit                  fr_cr = 1'b0;
  logic [31:0]         cap_word [4] = '{default: '0};
  logic [7:0]          cap_flag = '0;

  crc8fpr_pkg::res_t pending_frames [$];
  int   bytes_taken = 0;
  int   frames_due = 0;
  int   mismatch_count = 0;
  int   stall_cycles = 0;
  bit   steady = 1'b0;
  bit   hold_go = 1'b0;

  logic [15:0] phase_sync [NUM_PHASES];
  logic [7:0]  phase_base [NUM_PHASES];

  stim_row_t directed_rows [21] = '{
    '{8'h00, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'hff, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_CR, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_LF, SRC_LIT, 1'b1, crc8fpr_pkg::ST_SYNC},
    '{crc8fpr_pkg::BYTE_CR, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_LF, SRC_LIT, 1'b1, crc8fpr_pkg::ST_SYNC},
    '{8'h55, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'haa, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'h00, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'h00, SRC_CRC_RIGHT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_CR, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_LF, SRC_LIT, 1'b1, crc8fpr_pkg::ST_OK},
    '{8'h55, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'haa, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'h00, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'h00, SRC_CRC_WRONG, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_LF, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_CR, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{8'hff, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_CR, SRC_LIT, 1'b0, crc8fpr_pkg::ST_OK},
    '{crc8fpr_pkg::BYTE_LF, SRC_LIT, 1'b1, crc8fpr_pkg::ST_CRC}
  };

  crc8_framed_packet_receiver uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_status_o (frame_status),
    .word_one_o     (word_one),
    .word_two_o     (word_two),
    .word_three_o   (word_three),
    .word_four_o    (word_four),
    .control_flag_o (control_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    bit         fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ crc8fpr_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Advances the frame state by one received word; returns 1 when a frame closes.
  function automatic bit deframe_byte(input logic [7:0] b, output crc8fpr_pkg::res_t r);
    bit         was_cr;
    bit         done;
    logic [8:0] off;
    was_cr = fr_cr;
    done = 1'b0;
    r = '0;
    if (fr_phase == crc8fpr_pkg::PH_HUNT) begin
      cap_word = '{default: '0};
      cap_flag = '0;
      fr_pos = '0;
      fr_crc = '0;
      fr_len = '0;
      fr_crc_rx = '0;
      was_cr = 1'b0;
      fr_sync_bad = (b != cfg_sync[15:8]);
    end
    if (fr_pos >= {1'b0, cfg_base}) begin
      off = fr_pos - {1'b0, cfg_base};
      if (off < crc8fpr_pkg::FIELD_SPAN) begin
        cap_word[off[3:2]][{off[1:0], 3'b000} +: 8] = b;
      end else if (off == crc8fpr_pkg::FIELD_SPAN) begin
        cap_flag = b;
      end
    end
    case (fr_phase)
      crc8fpr_pkg::PH_HUNT: begin
        fr_crc = crc8_step(fr_crc, b);
        fr_phase = crc8fpr_pkg::PH_SYNC2;
      end
      crc8fpr_pkg::PH_SYNC2: begin
        fr_crc = crc8_step(fr_crc, b);
        if (b != cfg_sync[7:0]) begin
          fr_sync_bad = 1'b1;
        end
        if (fr_sync_bad) begin
          fr_phase = crc8fpr_pkg::PH_TRAILER;
          done = (b == crc8fpr_pkg::BYTE_LF) && was_cr;
        end else begin
          fr_phase = crc8fpr_pkg::PH_LEN;
        end
      end
      crc8fpr_pkg::PH_LEN: begin
        fr_crc = crc8_step(fr_crc, b);
        fr_len = b;
        fr_phase = (b == 8'd0) ? crc8fpr_pkg::PH_CRC : crc8fpr_pkg::PH_PAYLOAD;
      end
      crc8fpr_pkg::PH_PAYLOAD: begin
        fr_crc = crc8_step(fr_crc, b);
        if (fr_pos >= 9'd2 + {1'b0, fr_len}) begin
          fr_phase = crc8fpr_pkg::PH_CRC;
        end
      end
      crc8fpr_pkg::PH_CRC: begin
        fr_crc_rx = b;
        fr_phase = crc8fpr_pkg::PH_TRAILER;
      end
      default: begin
        done = (b == crc8fpr_pkg::BYTE_LF) && was_cr;
      end
    endcase
    fr_cr = (b == crc8fpr_pkg::BYTE_CR);
    if (fr_pos < crc8fpr_pkg::POS_MAX) begin
      fr_pos = fr_pos + 9'd1;
    end
    if (done) begin
      fr_phase = crc8fpr_pkg::PH_HUNT;
      fr_cr = 1'b0;
      if (fr_sync_bad) begin
        r.status = crc8fpr_pkg::ST_SYNC;
      end else if (fr_crc_rx != fr_crc) begin
        r.status = crc8fpr_pkg::ST_CRC;
      end else begin
        r.status = crc8fpr_pkg::ST_OK;
        r.word_one = cap_word[0];
        r.word_two = cap_word[1];
        r.word_three = cap_word[2];
        r.word_four = cap_word[3];
        r.flag = cap_flag;
      end
    end
    return done;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0: return crc8fpr_pkg::BYTE_CR;
      1: return crc8fpr_pkg::BYTE_LF;
      2: return cfg_sync[15:8];
      3: return cfg_sync[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input crc8fpr_pkg::res_t fixed = '0);
    crc8fpr_pkg::res_t r;
    bit                got;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    bytes_taken++;
    got = deframe_byte(b, r);
    if (typed) begin
      pending_frames.push_back(fixed);
    end else if (got) begin
      pending_frames.push_back(r);
    end
    if (got) begin
      frames_due++;
    end
  endtask

  task automatic write_reg(input crc8fpr_pkg::reg_e idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = crc8fpr_pkg::ADDR_W'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (idx == crc8fpr_pkg::REG_SYNC) begin
      cfg_sync = value[15:0];
    end else begin
      cfg_base = value[7:0];
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Closes whatever frame is open, then waits for every result to drain.
  task automatic settle();
    while (fr_phase != crc8fpr_pkg::PH_HUNT) begin
      push_byte(fr_cr ? crc8fpr_pkg::BYTE_LF : crc8fpr_pkg::BYTE_CR);
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Short frames with a bad sync word, each closed by CR LF, to fill the result side quickly.
  task automatic send_error_burst();
    repeat (BURST_FRAMES) begin
      push_byte(~cfg_sync[15:8]);
      push_byte(crc8fpr_pkg::BYTE_CR);
      push_byte(crc8fpr_pkg::BYTE_LF);
    end
  endtask

  task automatic send_frame();
    int         kind;
    int         len;
    logic [7:0] b;
    logic [7:0] b2;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 24) : $urandom_range(25, 255);
    if (kind < 62) begin
      push_byte(cfg_sync[15:8]);
      push_byte(cfg_sync[7:0]);
      push_byte(8'(len));
      repeat (len) push_byte(pick_byte());
      b = fr_crc;
      if ($urandom_range(0, 5) == 0) begin
        b = b ^ 8'($urandom_range(1, 255));
      end
      push_byte(b);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(pick_byte());
      end
      push_byte(crc8fpr_pkg::BYTE_CR);
      push_byte(crc8fpr_pkg::BYTE_LF);
    end else if (kind < 76) begin
      b = pick_byte();
      b2 = pick_byte();
      if (b == cfg_sync[15:8] && b2 == cfg_sync[7:0]) begin
        b2 = ~b2;
      end
      push_byte(b);
      push_byte(b2);
      repeat ($urandom_range(0, 6)) push_byte(pick_byte());
      push_byte(crc8fpr_pkg::BYTE_CR);
      push_byte(crc8fpr_pkg::BYTE_LF);
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 8)) push_byte(pick_byte());
    end else begin
      push_byte(cfg_sync[15:8]);
      push_byte(cfg_sync[7:0]);
      push_byte(8'(len));
      repeat ($urandom_range(0, len)) push_byte(pick_byte());
    end
  endtask

  // A valid frame whose trailer runs past the saturation point of the position count.
  task automatic send_long_frame();
    logic [7:0] b;
    push_byte(cfg_sync[15:8]);
    push_byte(cfg_sync[7:0]);
    push_byte(8'd16);
    repeat (16) push_byte(pick_byte());
    push_byte(fr_crc);
    repeat (LONG_JUNK) begin
      b = 8'($urandom_range(0, 255));
      if (b == crc8fpr_pkg::BYTE_LF) begin
        b = 8'hff;
      end
      push_byte(b);
    end
    push_byte(crc8fpr_pkg::BYTE_CR);
    push_byte(crc8fpr_pkg::BYTE_LF);
  endtask

  initial begin
    stim_row_t         row;
    logic [7:0]        b;
    crc8fpr_pkg::res_t fixed;
    int                start;
    phase_sync = '{crc8fpr_pkg::SYNC_RESET, 16'h0000, 16'h0d0a, 16'($urandom_range(0, 65535)),
                   16'hffff, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    phase_base = '{crc8fpr_pkg::BASE_RESET, 8'd0, 8'd3, 8'($urandom_range(0, 20)), 8'd255,
                   8'($urandom_range(0, 254)), 8'($urandom_range(0, 8))};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < $size(directed_rows); n++) begin
      row = directed_rows[n];
      case (row.src)
        SRC_CRC_RIGHT: b = fr_crc;
        SRC_CRC_WRONG: b = fr_crc ^ 8'h5a;
        default: b = row.value;
      endcase
      fixed = '0;
      fixed.status = row.status;
      push_byte(b, row.typed, fixed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(crc8fpr_pkg::REG_SYNC, 32'(phase_sync[p]));
      write_reg(crc8fpr_pkg::REG_BASE, 32'(phase_base[p]));
      steady = (p == 3);
      start = bytes_taken;
      if (p == 1) begin
        hold_go = 1'b1;
        send_error_burst();
      end
      if (phase_base[p] == 8'd255) begin
        send_long_frame();
      end
      while (bytes_taken - start < PHASE_WORDS) begin
        send_frame();
      end
      steady = 1'b0;
    end
    while (frames_due < MIN_FRAMES) begin
      send_frame();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off to fill the block.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && hold_go) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%t: %s expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    crc8fpr_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%t: unexpected result, status %0d", $realtime, frame_status);
        end
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_status", 32'(want.status), 32'(frame_status));
        check_field("word_one", want.word_one, word_one);
        check_field("word_two", want.word_two, word_two);
        check_field("word_three", want.word_three, word_three);
        check_field("word_four", want.word_four, word_four);
        check_field("control_flag", 32'(want.flag), 32'(control_flag));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
